// ----- design/bit_parallel_approx_string_match_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the bit-parallel approximate string matcher
// Simulation builds get concurrent checks; synthesis builds get nothing.
// ----------------------------------------------------------------------------
`ifndef BIT_PARALLEL_APPROX_STRING_MATCH_TOP_DEFINES_SVH
`define BIT_PARALLEL_APPROX_STRING_MATCH_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define BPASM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpasm check failed");
// The consequent must hold in the cycle after the antecedent.
`define BPASM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpasm check failed");
`else
`define BPASM_ASSERT_SAME(label, ante, cons)
`define BPASM_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- design/bpasm_pkg.sv -----
// ----------------------------------------------------------------------------
// bpasm_pkg
// Shared constants, opcodes and types of the bit-parallel string matcher.
// ----------------------------------------------------------------------------
package bpasm_pkg;

  // Word and alphabet geometry.
  localparam int WORD_BITS     = 64;
  localparam int ALPHABET_SIZE = 256;
  localparam int SYM_W         = 8;
  localparam int POS_W         = 6;
  localparam int LEN_W         = 7;
  localparam int OP_W          = 2;
  localparam int CFG_IDX_W     = 2;

  // Item opcodes.
  localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
  localparam logic [OP_W-1:0] OP_PATTERN = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;
  localparam logic [OP_W-1:0] OP_TEXT    = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_THRESHOLD = 2'd1;

  typedef logic [WORD_BITS-1:0] word_t;

  // Access request to the match-mask table.
  typedef struct packed {
    logic             rd_en;
    logic [SYM_W-1:0] rd_addr;
    logic             wr_en;
    logic [SYM_W-1:0] wr_addr;
    word_t            wr_data;
    logic             clear;
  } mask_req_t;

  // Commit strobes for the search state.
  typedef struct packed {
    logic restart;
    logic text;
  } step_t;

endpackage

// ----- design/bpasm_mask_ram.sv -----
// ----------------------------------------------------------------------------
// bpasm_mask_ram
// Match-mask table: one synchronous memory with registered read, a valid bit
// per entry so that a clear drops every entry at once, and write-to-read forwarding.
// ----------------------------------------------------------------------------
module bpasm_mask_ram
  import bpasm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  mask_req_t req,
  output word_t     rd_data
);

  word_t                    mem [ALPHABET_SIZE];
  word_t                    mem_q;
  logic [ALPHABET_SIZE-1:0] valid;
  logic [SYM_W-1:0]         rd_addr_q;
  logic                     fwd_hit;
  word_t                    fwd_data;

  // Memory write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Memory read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      mem_q     <= mem[req.rd_addr];
      rd_addr_q <= req.rd_addr;
      fwd_data  <= req.wr_data;
    end
  end

  // A write in the same cycle as the read is not seen by the memory output,
  // so it is captured for forwarding.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (req.rd_en) begin
      fwd_hit <= req.wr_en && (req.wr_addr == req.rd_addr);
    end
  end

  // Entry valid bits; a clear drops them all at once.
  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  // An entry not written since the last clear reads as zero.
  always_comb begin
    if (fwd_hit) begin
      rd_data = fwd_data;
    end else if (valid[rd_addr_q]) begin
      rd_data = mem_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

// ----- design/bpasm_core.sv -----
// ----------------------------------------------------------------------------
// bpasm_core
// Search state (vertical delta vectors and score) and the per-character
// bit-vector update.
// ----------------------------------------------------------------------------
module bpasm_core
  import bpasm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] pattern_length,
  input  logic [LEN_W-1:0] match_threshold,
  input  step_t            step,
  input  word_t            eq,
  output logic             match_next,
  output logic [LEN_W-1:0] distance_next
);

  word_t            vp;
  word_t            vn;
  logic [LEN_W-1:0] score;

  logic [LEN_W-1:0] len_eff;
  logic [POS_W-1:0] top;
  logic [LEN_W-1:0] thr;
  word_t            mmask;
  word_t            vp_m;
  word_t            vn_m;
  word_t            vx;
  word_t            sum;
  word_t            hx;
  word_t            hp;
  word_t            hn;
  word_t            hp_s;
  word_t            hn_s;
  word_t            vp_next;
  word_t            vn_next;
  logic             up;
  logic             down;

  // Effective length, clamped to one word, and its active mask.
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (pattern_length > LEN_W'(WORD_BITS)) begin
      len_eff = LEN_W'(WORD_BITS);
    end else begin
      len_eff = pattern_length;
    end
    top = POS_W'(len_eff - LEN_W'(1));
    for (int i = 0; i < WORD_BITS; i++) begin
      mmask[i] = (LEN_W'(i) < len_eff);
    end
  end

  // Column update: one carry chain and bitwise logic.
  always_comb begin
    vp_m    = vp & mmask;
    vn_m    = vn & mmask;
    vx      = (eq | vn_m) & mmask;
    sum     = (eq & vp_m) + vp_m;
    hx      = ((sum ^ vp_m) | eq) & mmask;
    hp      = (vn_m | ~(vp_m | hx)) & mmask;
    hn      = (vp_m & hx) & mmask;
    up      = hp[top] && !hn[top];
    down    = hn[top] && !hp[top];
    hp_s    = (hp << 1) & mmask;
    hn_s    = (hn << 1) & mmask;
    vp_next = (hn_s | ~(hp_s | vx)) & mmask;
    vn_next = (hp_s & vx) & mmask;
  end

  // Score moves by one and saturates at both ends.
  always_comb begin
    distance_next = score;
    if (up && (score != '1)) begin
      distance_next = score + LEN_W'(1);
    end else if (down && (score != '0)) begin
      distance_next = score - LEN_W'(1);
    end
    thr        = (match_threshold > len_eff) ? '0 : match_threshold;
    match_next = (distance_next <= thr);
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vp    <= '1;
      vn    <= '0;
      score <= LEN_W'(1);
    end else if (step.restart) begin
      vp    <= mmask;
      vn    <= '0;
      score <= len_eff;
    end else if (step.text) begin
      vp    <= vp_next;
      vn    <= vn_next;
      score <= distance_next;
    end
  end

endmodule

// ----- design/bit_parallel_approx_string_match_top.sv -----
// ----------------------------------------------------------------------------
// bit_parallel_approx_string_match_top
// Bit-vector approximate matcher of a pattern of up to 64 symbols against a
// byte stream, with a 256-entry match-mask table.
// ----------------------------------------------------------------------------
// The match-mask table is read at the word's symbol on the edge that accepts
// the word. The word is then applied from the second stage. A pattern word
// writes its table entry back. A restart word resets the search vectors and
// score. A text word updates them and loads its result into the output
// register, from which the result is offered. A word is taken every cycle,
// whatever its opcode, with one exception: a text word waits in the second
// stage, and stalls the input, while the output register still holds a
// result that the receiver has not taken. The rate is set by the loop
// through the 64-bit add of the vector update and by the table's one read
// and one write port per cycle. Clearing the table drops every valid bit at
// once and there is no clearing pass after reset. Configuration writes are
// always taken and must arrive while the block is idle.
// ----------------------------------------------------------------------------
`include "bit_parallel_approx_string_match_top_defines.svh"

module bit_parallel_approx_string_match_top
  import bpasm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Input words
  input  logic                 item_valid,
  output logic                 item_stall,
  input  logic [OP_W-1:0]      opcode,
  input  logic [SYM_W-1:0]     symbol,
  input  logic [POS_W-1:0]     position,
  // Result words
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 match,
  output logic [LEN_W-1:0]     distance,
  // Configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data
);

  logic [LEN_W-1:0] pattern_length;
  logic [LEN_W-1:0] match_threshold;

  logic             s1_valid;
  logic [OP_W-1:0]  s1_opcode;
  logic [SYM_W-1:0] s1_symbol;
  logic [POS_W-1:0] s1_position;

  logic             accept;
  logic             s1_go;
  logic             out_free;
  mask_req_t        req;
  word_t            rd_data;
  step_t            step;
  logic             match_next;
  logic [LEN_W-1:0] distance_next;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length  <= LEN_W'(1);
      match_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PATTERN_LENGTH) begin
        pattern_length <= cfg_data;
      end else if (cfg_index == REG_MATCH_THRESHOLD) begin
        match_threshold <= cfg_data;
      end
    end
  end

  // Handshake: only a text word waiting on a full, stalled output register holds.
  assign out_free   = !result_valid || !result_stall;
  assign s1_go      = s1_valid && ((s1_opcode != OP_TEXT) || out_free);
  assign item_stall = s1_valid && !s1_go;
  assign accept     = item_valid && !item_stall;

  // Table read stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_opcode   <= opcode;
      s1_symbol   <= symbol;
      s1_position <= position;
    end
  end

  // Table access: read for the incoming word, write back for the word in
  // the second stage.
  always_comb begin
    req.rd_en   = accept;
    req.rd_addr = symbol;
    req.wr_en   = s1_go && (s1_opcode == OP_PATTERN);
    req.wr_addr = s1_symbol;
    req.wr_data = rd_data | (word_t'(1) << s1_position);
    req.clear   = s1_go && (s1_opcode == OP_CLEAR);
  end

  bpasm_mask_ram u_mask_ram (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  // Search state update.
  assign step.restart = s1_go && (s1_opcode == OP_RESTART);
  assign step.text    = s1_go && (s1_opcode == OP_TEXT);

  bpasm_core u_core (
    .clk             (clk),
    .rst             (rst),
    .pattern_length  (pattern_length),
    .match_threshold (match_threshold),
    .step            (step),
    .eq              (rd_data),
    .match_next      (match_next),
    .distance_next   (distance_next)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step.text) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.text) begin
      match    <= match_next;
      distance <= distance_next;
    end
  end

  // Checks.
  `BPASM_ASSERT_SAME(a_stall_only_when_held, item_stall, s1_valid && s1_opcode == OP_TEXT)
  `BPASM_ASSERT_NEXT(a_text_gives_result, step.text, result_valid)
  `BPASM_ASSERT_SAME(a_result_from_text, $rose(result_valid), $past(step.text))
  `BPASM_ASSERT_SAME(a_one_commit, 1'b1, !(step.text && step.restart))

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the bit-parallel approximate string matcher
// Loads patterns, restarts searches and streams text words into the block.
// Expected scores come from a bit-vector model kept inside the bench and are
// checked field by field, in order. The test runs under several sender and
// receiver idling phases, and includes one long hold on the result channel.
// ----------------------------------------------------------------------------
module tb_top;
  import bpasm_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int PHASE_WORDS   = 350;

  typedef struct packed {
    logic             hit;
    logic [LEN_W-1:0] edits;
  } score_word_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic [OP_W-1:0]      opcode = OP_CLEAR;
  logic [SYM_W-1:0]     symbol = '0;
  logic [POS_W-1:0]     position = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic                 match;
  logic [LEN_W-1:0]     distance;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_PATTERN_LENGTH;
  logic [LEN_W-1:0]     cfg_data = '0;

  // Bench copy of the search state and the register settings.
  word_t            mask_rows [ALPHABET_SIZE];
  word_t            vert_pos;
  word_t            vert_neg;
  logic [LEN_W-1:0] search_score;
  logic [LEN_W-1:0] cfg_length;
  logic [LEN_W-1:0] cfg_threshold;

  score_word_t pending_scores [$];

  int fail_count = 0;
  int words_sent = 0;
  int scores_checked = 0;
  int settings_written = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  bit_parallel_approx_string_match_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .opcode       (opcode),
    .symbol       (symbol),
    .position     (position),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .match        (match),
    .distance     (distance),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #10 clk = ~clk;

  // A length of zero acts as one, anything above the word width as the width.
  function automatic int effective_length(input logic [LEN_W-1:0] raw);
    int len;
    len = raw;
    if (len == 0) begin
      len = 1;
    end
    if (len > WORD_BITS) begin
      len = WORD_BITS;
    end
    return len;
  endfunction

  // Applies one accepted word to the bench state; text words queue a score.
  task automatic advance_search(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                                input logic [POS_W-1:0] pos);
    int          len;
    int          thr;
    word_t       act_mask, top_bit, eq, vp, vn, vx, hx, hp, hn;
    score_word_t sw;
    len      = effective_length(cfg_length);
    act_mask = {WORD_BITS{1'b1}} >> (WORD_BITS - len);
    top_bit  = word_t'(1) << (len - 1);
    case (op)
      OP_CLEAR: begin
        foreach (mask_rows[i]) mask_rows[i] = '0;
      end
      OP_PATTERN: begin
        mask_rows[sym][pos] = 1'b1;
      end
      OP_RESTART: begin
        vert_pos     = act_mask;
        vert_neg     = '0;
        search_score = LEN_W'(len);
      end
      default: begin
        eq = mask_rows[sym];
        vp = vert_pos & act_mask;
        vn = vert_neg & act_mask;
        vx = (eq | vn) & act_mask;
        hx = ((((eq & vp) + vp) ^ vp) | eq) & act_mask;
        hp = (vn | ~(vp | hx)) & act_mask;
        hn = (vp & hx) & act_mask;
        // The score follows the horizontal delta at the pattern's last row.
        if ((hp & top_bit) != 0 && (hn & top_bit) == 0) begin
          if (search_score != 7'd127) search_score = search_score + 1'b1;
        end else if ((hn & top_bit) != 0 && (hp & top_bit) == 0) begin
          if (search_score != 7'd0) search_score = search_score - 1'b1;
        end
        hp       = (hp << 1) & act_mask;
        hn       = (hn << 1) & act_mask;
        vert_pos = (hn | ~(hp | vx)) & act_mask;
        vert_neg = (hp & vx) & act_mask;
        thr = cfg_threshold;
        if (thr > len) begin
          thr = 0;
        end
        sw.hit   = (search_score <= thr);
        sw.edits = search_score;
        pending_scores.push_back(sw);
      end
    endcase
  endtask

  // Offers one word, after a random idle gap, and holds it until it is taken.
  task automatic send_word(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym,
                           input logic [POS_W-1:0] pos);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 30) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode     <= op;
    symbol     <= sym;
    position   <= pos;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    advance_search(op, sym, pos);
    words_sent++;
  endtask

  // Stops offering words and waits until every score is back and the
  // pipeline has had time to finish any word that gives no result.
  task automatic settle_block();
    item_valid <= 1'b0;
    do @(posedge clk); while (pending_scores.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers back to back; the block must be idle.
  task automatic set_search_config(input logic [LEN_W-1:0] len_raw,
                                   input logic [LEN_W-1:0] thr_raw);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PATTERN_LENGTH;
    cfg_data  <= len_raw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_length = len_raw;
    cfg_index <= REG_MATCH_THRESHOLD;
    cfg_data  <= thr_raw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_threshold = thr_raw;
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  function automatic logic [LEN_W-1:0] pick_length();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd64;
      3: return LEN_W'($urandom_range(127, 65));
      default: return LEN_W'($urandom_range(64, 1));
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_threshold(input logic [LEN_W-1:0] len_raw);
    int len;
    len = effective_length(len_raw);
    case ($urandom_range(7))
      0: return 7'd0;
      1: return 7'd127;
      2: return LEN_W'(len);
      default: return LEN_W'($urandom_range(len + 1 < 4 ? len + 1 : 4, 0));
    endcase
  endfunction

  // One search: a new setting, a fresh pattern and a restart, then text drawn
  // mostly from the pattern's own small alphabet so that matches do occur.
  // With keep_state the length changes under a running search instead.
  task automatic run_search(input bit keep_state, input int text_words);
    logic [LEN_W-1:0] len_raw;
    logic [LEN_W-1:0] thr_raw;
    logic [SYM_W-1:0] base;
    logic [SYM_W-1:0] pat [WORD_BITS];
    int               len;
    int               idx;
    int               r;
    len_raw = pick_length();
    thr_raw = keep_state ? cfg_threshold : pick_threshold(len_raw);
    settle_block();
    set_search_config(len_raw, thr_raw);
    len  = effective_length(len_raw);
    base = SYM_W'($urandom_range(255));
    for (int p = 0; p < WORD_BITS; p++) begin
      pat[p] = ($urandom_range(9) == 0) ? SYM_W'($urandom_range(255))
                                        : SYM_W'(base + $urandom_range(3));
    end
    if (!keep_state) begin
      send_word(OP_CLEAR, SYM_W'($urandom), POS_W'($urandom));
      for (int p = 0; p < len; p++) send_word(OP_PATTERN, pat[p], POS_W'(p));
      // Now and then a stray entry, often above the active length.
      if ($urandom_range(3) == 0) begin
        send_word(OP_PATTERN, SYM_W'(base + $urandom_range(3)), POS_W'($urandom_range(63)));
      end
      send_word(OP_RESTART, SYM_W'($urandom), POS_W'($urandom));
    end
    idx = 0;
    for (int i = 0; i < text_words; i++) begin
      r = $urandom_range(99);
      if (r < 4) begin
        send_word(OP_W'($urandom_range(3)), SYM_W'($urandom), POS_W'($urandom));
      end else if (r < 55) begin
        send_word(OP_TEXT, pat[idx % len], POS_W'($urandom));
        idx++;
      end else if (r < 90) begin
        send_word(OP_TEXT, SYM_W'(base + $urandom_range(3)), POS_W'($urandom));
      end else begin
        send_word(OP_TEXT, SYM_W'($urandom_range(255)), POS_W'($urandom));
      end
    end
  endtask

  // Text straight after reset: length one, threshold zero, empty table.
  task automatic test_reset_state();
    send_word(OP_TEXT, 8'h00, 6'h00);
    send_word(OP_TEXT, 8'hFF, 6'h3F);
    settle_block();
  endtask

  // Exact match, mismatch, hidden positions, length change without restart,
  // length zero, length above the word, threshold above the length.
  task automatic test_directed_cases();
    set_search_config(7'd4, 7'd1);
    send_word(OP_CLEAR, 8'hFF, 6'h3F);
    send_word(OP_PATTERN, 8'h00, 6'd0);
    send_word(OP_PATTERN, 8'hFF, 6'd1);
    send_word(OP_PATTERN, 8'h00, 6'd2);
    send_word(OP_PATTERN, 8'h55, 6'd3);
    send_word(OP_PATTERN, 8'h55, 6'd63);
    send_word(OP_RESTART, 8'h00, 6'd0);
    send_word(OP_TEXT, 8'h00, 6'd0);
    send_word(OP_TEXT, 8'hFF, 6'd0);
    send_word(OP_TEXT, 8'h00, 6'd0);
    send_word(OP_TEXT, 8'h55, 6'd0);
    send_word(OP_TEXT, 8'hAA, 6'd0);
    settle_block();
    set_search_config(7'd2, 7'd1);
    send_word(OP_TEXT, 8'h00, 6'd0);
    send_word(OP_TEXT, 8'hFF, 6'd0);
    settle_block();
    set_search_config(7'd0, 7'd127);
    send_word(OP_TEXT, 8'h00, 6'd0);
    send_word(OP_RESTART, 8'h00, 6'd0);
    send_word(OP_TEXT, 8'hFF, 6'd0);
    send_word(OP_TEXT, 8'h00, 6'd0);
    settle_block();
    set_search_config(7'd127, 7'd64);
    send_word(OP_RESTART, 8'h00, 6'd0);
    send_word(OP_TEXT, 8'h00, 6'd0);
    send_word(OP_TEXT, 8'h55, 6'd0);
    settle_block();
  endtask

  // Random searches under each idling phase in turn.
  task automatic test_random_searches();
    int first_word;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      first_word = words_sent;
      while (words_sent - first_word < PHASE_WORDS) begin
        case ($urandom_range(7))
          0: run_search(1'b1, $urandom_range(40, 10));
          1: begin
            // Pure noise words of every kind.
            for (int i = 0; i < 30; i++) begin
              send_word(OP_W'($urandom), SYM_W'($urandom), POS_W'($urandom));
            end
          end
          default: run_search(1'b0, $urandom_range(60, 10));
        endcase
      end
      settle_block();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Result channel held off for a long stretch while text words keep coming,
  // so the block backs up and stalls its input.
  task automatic test_output_backpressure();
    settle_block();
    hold_token++;
    run_search(1'b0, 150);
    settle_block();
  endtask

  // Receiver: a long hold when asked for one, otherwise random stalls.
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      result_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Every accepted result word is checked against the oldest expected score.
  always @(posedge clk) begin
    score_word_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_scores.size() == 0) begin
        $error("result word with no score expected: match %0b, distance %0d", match, distance);
        fail_count++;
      end else begin
        want = pending_scores.pop_front();
        scores_checked++;
        if (match !== want.hit) begin
          $error("match mismatch: expected %0b, got %0b", want.hit, match);
          fail_count++;
        end
        if (distance !== want.edits) begin
          $error("distance mismatch: expected %0d, got %0d", want.edits, distance);
          fail_count++;
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bit_parallel_approx_string_match_top verification failed");
      $finish;
    end
  end

  // Reset state of the bench copy matches that of the block.
  initial begin
    foreach (mask_rows[i]) mask_rows[i] = '0;
    vert_pos      = {WORD_BITS{1'b1}};
    vert_neg      = '0;
    search_score  = 7'd1;
    cfg_length    = 7'd1;
    cfg_threshold = 7'd0;
  end

  // Test sequence.
  initial begin
    rst <= 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_directed_cases();
    test_random_searches();
    test_output_backpressure();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_scores.size() != 0) begin
      $error("%0d expected scores never arrived", pending_scores.size());
      fail_count++;
    end
    $display("Sent %0d words and checked %0d scores over %0d register settings,",
             words_sent, scores_checked, settings_written);
    $display("under idle-free, sender-idle, receiver-stall and mixed phases plus one long hold.");
    if (fail_count == 0) begin
      $display("bit_parallel_approx_string_match_top verification clean");
    end else begin
      $display("bit_parallel_approx_string_match_top verification failed");
    end
    $finish;
  end

endmodule
